// ----- design/cbgeq_pkg.sv -----
// Shared types, constants and rounding helpers for the cascaded biquad equalizer.
`timescale 1ns / 1ps

package cbgeq_pkg;

  // Field widths
  localparam int SAMPLE_W      = 24;
  localparam int COEF_W        = 32;
  localparam int DLY_W         = 40;
  localparam int PROD_W        = COEF_W + SAMPLE_W;
  localparam int ACC_W         = 62;
  localparam int BAND_SEL_W    = 4;
  localparam int COEF_SEL_W    = 3;

  // Section layout
  localparam int NUM_BANDS_DEF  = 10;
  localparam int COEFS_PER_BAND = 5;
  localparam int DLY_PER_BAND   = 2;

  // Binary point positions
  localparam int Y_SHIFT = 28;
  localparam int D_SHIFT = 20;
  localparam int YQ_W    = ACC_W - Y_SHIFT;
  localparam int DQ_W    = ACC_W - D_SHIFT;

  // 1.0 in Q4.28, reset value of every b0
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(32'h1000_0000);

  // Request opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  // Coefficient slots within a band
  localparam logic [COEF_SEL_W-1:0] COEF_B0 = 3'd0;
  localparam logic [COEF_SEL_W-1:0] COEF_B1 = 3'd1;
  localparam logic [COEF_SEL_W-1:0] COEF_B2 = 3'd2;
  localparam logic [COEF_SEL_W-1:0] COEF_A1 = 3'd3;
  localparam logic [COEF_SEL_W-1:0] COEF_A2 = 3'd4;

  // Delay slots within a band
  localparam logic DLY_S1 = 1'b0;
  localparam logic DLY_S2 = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  // Phase schedule of one section (its delay write-back overlaps PH_HEAD and PH_MUL_B0 of the next)
  typedef enum logic [2:0] {
    PH_HEAD,
    PH_MUL_B0,
    PH_ACC_S1,
    PH_Y,
    PH_ACC2,
    PH_SUB1
  } phase_e;

  typedef enum logic [1:0] {
    ACC1_HOLD,
    ACC1_LOAD,
    ACC1_SUB
  } acc1_op_e;

  typedef enum logic [1:0] {
    ACC2_HOLD,
    ACC2_LOAD,
    ACC2_SUB
  } acc2_op_e;

  // Sequencer to datapath controls
  typedef struct packed {
    logic     y_load_in;
    logic     y_load_acc;
    logic     mul_en;
    acc1_op_e acc1_op;
    acc2_op_e acc2_op;
  } mac_ctrl_t;

  // Round to nearest (ties up) at 2^-23, saturate to a sample
  function automatic logic signed [SAMPLE_W-1:0] rsat_y(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    logic signed [YQ_W-1:0]  q;
    logic signed [YQ_W-1:0]  qmax;
    logic signed [YQ_W-1:0]  qmin;
    t    = v + (ACC_W'(1) << (Y_SHIFT - 1));
    q    = t[ACC_W-1:Y_SHIFT];
    qmax = {{(YQ_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
    qmin = {{(YQ_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};
    if (q > qmax) begin
      return qmax[SAMPLE_W-1:0];
    end else if (q < qmin) begin
      return qmin[SAMPLE_W-1:0];
    end
    return q[SAMPLE_W-1:0];
  endfunction

  // Round to nearest (ties up) at 2^-31, saturate to a delay word
  function automatic logic signed [DLY_W-1:0] rsat_d(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    logic signed [DQ_W-1:0]  q;
    logic signed [DQ_W-1:0]  qmax;
    logic signed [DQ_W-1:0]  qmin;
    t    = v + (ACC_W'(1) << (D_SHIFT - 1));
    q    = t[ACC_W-1:D_SHIFT];
    qmax = {{(DQ_W-DLY_W+1){1'b0}}, {(DLY_W-1){1'b1}}};
    qmin = {{(DQ_W-DLY_W+1){1'b1}}, {(DLY_W-1){1'b0}}};
    if (q > qmax) begin
      return qmax[DLY_W-1:0];
    end else if (q < qmin) begin
      return qmin[DLY_W-1:0];
    end
    return q[DLY_W-1:0];
  endfunction

endpackage

// ----- design/cbgeq_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps

module cbgeq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 50,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/cbgeq_store.sv -----
// Coefficient and section delay memories with per-entry valid bits for reset values.
`timescale 1ns / 1ps

module cbgeq_store
  import cbgeq_pkg::*;
#(
  parameter int NUM_BANDS = NUM_BANDS_DEF,
  localparam int NUM_COEF = NUM_BANDS * COEFS_PER_BAND,
  localparam int NUM_DLY  = NUM_BANDS * DLY_PER_BAND,
  localparam int CADDR_W  = $clog2(NUM_COEF),
  localparam int DADDR_W  = $clog2(NUM_DLY)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // coefficient side
  input  logic                     c_we_i,
  input  logic [CADDR_W-1:0]       c_waddr_i,
  input  logic [COEF_W-1:0]        c_wdata_i,
  input  logic                     c_re_i,
  input  logic [CADDR_W-1:0]       c_raddr_i,
  input  logic                     c_rb0_i,
  output logic signed [COEF_W-1:0] coef_o,
  // delay side
  input  logic                     d_we_i,
  input  logic [DADDR_W-1:0]       d_waddr_i,
  input  logic [DLY_W-1:0]         d_wdata_i,
  input  logic                     d_re_i,
  input  logic [DADDR_W-1:0]       d_raddr_i,
  output logic signed [DLY_W-1:0]  dly_o
);

  logic [NUM_COEF-1:0] c_vld_q;
  logic [NUM_DLY-1:0]  d_vld_q;
  logic                c_hit_q;
  logic                c_b0_q;
  logic                d_hit_q;
  logic [COEF_W-1:0]   c_rdata;
  logic [DLY_W-1:0]    d_rdata;

  cbgeq_ram #(
    .WIDTH (COEF_W),
    .DEPTH (NUM_COEF)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (c_we_i),
    .waddr_i (c_waddr_i),
    .wdata_i (c_wdata_i),
    .re_i    (c_re_i),
    .raddr_i (c_raddr_i),
    .rdata_o (c_rdata)
  );

  cbgeq_ram #(
    .WIDTH (DLY_W),
    .DEPTH (NUM_DLY)
  ) u_dly_ram (
    .clk_i   (clk_i),
    .we_i    (d_we_i),
    .waddr_i (d_waddr_i),
    .wdata_i (d_wdata_i),
    .re_i    (d_re_i),
    .raddr_i (d_raddr_i),
    .rdata_o (d_rdata)
  );

  // Valid bits: an entry never written reads as its reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= '0;
      d_vld_q <= '0;
    end else begin
      if (c_we_i) begin
        c_vld_q[c_waddr_i] <= 1'b1;
      end
      if (d_we_i) begin
        d_vld_q[d_waddr_i] <= 1'b1;
      end
    end
  end

  // Track validity of the word in flight alongside the RAM read
  always_ff @(posedge clk_i) begin
    if (c_re_i) begin
      c_hit_q <= c_vld_q[c_raddr_i];
      c_b0_q  <= c_rb0_i;
    end
    if (d_re_i) begin
      d_hit_q <= d_vld_q[d_raddr_i];
    end
  end

  assign coef_o = c_hit_q ? c_rdata : (c_b0_q ? COEF_ONE : '0);
  assign dly_o  = d_hit_q ? d_rdata : '0;

endmodule

// ----- design/cbgeq_mac.sv -----
// Shared multiply-accumulate datapath for the biquad sections.
`timescale 1ns / 1ps

module cbgeq_mac
  import cbgeq_pkg::*;
(
  input  logic                       clk_i,
  input  mac_ctrl_t                  ctrl_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic signed [COEF_W-1:0]   coef_i,
  input  logic signed [DLY_W-1:0]    dly_i,
  output logic signed [SAMPLE_W-1:0] y_o,
  output logic signed [DLY_W-1:0]    s1_new_o,
  output logic signed [DLY_W-1:0]    s2_new_o
);

  // y_q is the section input before the y update, the section output after
  logic signed [SAMPLE_W-1:0] y_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc1_q;
  logic signed [ACC_W-1:0]    acc2_q;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [ACC_W-1:0]    dly_ext;

  assign prod_ext = ACC_W'(prod_q);
  assign dly_ext  = ACC_W'(dly_i) <<< D_SHIFT;

  // Sample register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.y_load_in) begin
      y_q <= sample_i;
    end else if (ctrl_i.y_load_acc) begin
      y_q <= rsat_y(acc1_q);
    end
  end

  // Single multiplier, registered product
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= coef_i * y_q;
    end
  end

  // acc1: y sum, then new s1; acc2: new s2
  always_ff @(posedge clk_i) begin
    case (ctrl_i.acc1_op)
      ACC1_LOAD: acc1_q <= prod_ext + dly_ext;
      ACC1_SUB:  acc1_q <= acc1_q - prod_ext;
      default:   acc1_q <= acc1_q;
    endcase
    case (ctrl_i.acc2_op)
      ACC2_LOAD: acc2_q <= prod_ext;
      ACC2_SUB:  acc2_q <= acc2_q - prod_ext;
      default:   acc2_q <= acc2_q;
    endcase
  end

  assign y_o      = y_q;
  assign s1_new_o = rsat_d(acc1_q);
  assign s2_new_o = rsat_d(acc2_q);

endmodule

// ----- design/cascaded_biquad_graphic_eq.sv -----
// Top level: request sequencer, output register and memory-backed biquad cascade.
`timescale 1ns / 1ps

// Mono graphic equalizer: NUM_BANDS transposed direct form II biquads in series.
// Input channel (in_valid_i/in_ready_o) carries either an audio sample request
// (op_i = 0) or a coefficient write (op_i = 1). Output channel
// (out_valid_o/out_ready_i) returns one sample_out_o per audio sample request.
// Coefficient writes return nothing, and writes to a band or
// slot that does not exist are dropped.
// Coefficients and section delays live in two RAMs; one shared multiplier
// walks five products per section in turn. A sample request is accepted only
// while the sequencer is idle, so the next request waits until the result of
// the last has gone to the output register. With eq_enable at 0 the sample
// passes unchanged and no delay changes.
// The output register holds a result until it is taken; the next request can
// be accepted meanwhile, and only a second result waits for the register.
// Reset (rst_ni low) sets eq_enable, and clears the valid bits of both RAMs, so
// every section reads b0 = 1.0, other coefficients 0, delays 0; no clearing
// pass is needed and requests are accepted right after reset.
// cfg_we_i/cfg_wdata_i write eq_enable; write it only while the block is idle.

module cascaded_biquad_graphic_eq
  import cbgeq_pkg::*;
#(
  parameter int NUM_BANDS = NUM_BANDS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_we_i,
  input  logic                       cfg_wdata_i,
  // request channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       op_i,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  input  logic [BAND_SEL_W-1:0]      band_select_i,
  input  logic [COEF_SEL_W-1:0]      coef_select_i,
  input  logic signed [COEF_W-1:0]   coef_value_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o
);

  localparam int NUM_COEF = NUM_BANDS * COEFS_PER_BAND;
  localparam int NUM_DLY  = NUM_BANDS * DLY_PER_BAND;
  localparam int CADDR_W  = $clog2(NUM_COEF);
  localparam int DADDR_W  = $clog2(NUM_DLY);
  localparam int BANDC_W  = $clog2(NUM_BANDS + 1);

  state_e                     state_q, state_d;
  phase_e                     ph_q, ph_d;
  logic [BANDC_W-1:0]         band_q, band_d;
  logic                       en_q;
  logic                       out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] out_data_q, out_data_d;

  mac_ctrl_t                  mac_ctrl;
  logic                       c_we;
  logic [CADDR_W-1:0]         c_waddr;
  logic                       c_re;
  logic [CADDR_W-1:0]         c_raddr;
  logic                       c_rb0;
  logic                       d_we;
  logic [DADDR_W-1:0]         d_waddr;
  logic [DLY_W-1:0]           d_wdata;
  logic                       d_re;
  logic [DADDR_W-1:0]         d_raddr;
  logic signed [COEF_W-1:0]   coef;
  logic signed [DLY_W-1:0]    dly;
  logic signed [SAMPLE_W-1:0] y;
  logic signed [DLY_W-1:0]    s1_new;
  logic signed [DLY_W-1:0]    s2_new;
  logic                       coef_ok;
  logic                       head;
  logic                       prev;
  logic [BANDC_W-1:0]         band_prev;

  function automatic logic [CADDR_W-1:0] coef_addr(input logic [BANDC_W-1:0] b,
                                                   input logic [COEF_SEL_W-1:0] s);
    return CADDR_W'(int'(b) * COEFS_PER_BAND + int'(s));
  endfunction

  function automatic logic [DADDR_W-1:0] dly_addr(input logic [BANDC_W-1:0] b,
                                                  input logic k);
    return DADDR_W'(int'(b) * DLY_PER_BAND + int'(k));
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign coef_ok    = (int'(band_select_i) < NUM_BANDS) && (coef_select_i <= COEF_A2);
  assign c_waddr    = CADDR_W'(int'(band_select_i) * COEFS_PER_BAND + int'(coef_select_i));
  assign head       = (band_q != BANDC_W'(NUM_BANDS));
  assign prev       = (band_q != '0);
  assign band_prev  = band_q - BANDC_W'(1);

  cbgeq_store #(
    .NUM_BANDS (NUM_BANDS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .c_we_i    (c_we),
    .c_waddr_i (c_waddr),
    .c_wdata_i (coef_value_i),
    .c_re_i    (c_re),
    .c_raddr_i (c_raddr),
    .c_rb0_i   (c_rb0),
    .coef_o    (coef),
    .d_we_i    (d_we),
    .d_waddr_i (d_waddr),
    .d_wdata_i (d_wdata),
    .d_re_i    (d_re),
    .d_raddr_i (d_raddr),
    .dly_o     (dly)
  );

  cbgeq_mac u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .sample_i (sample_in_i),
    .coef_i   (coef),
    .dly_i    (dly),
    .y_o      (y),
    .s1_new_o (s1_new),
    .s2_new_o (s2_new)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= PH_HEAD;
      band_q      <= '0;
      en_q        <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      band_q      <= band_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        en_q <= cfg_wdata_i;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  // Sequencer: next state, memory accesses and datapath controls.
  // Band b runs phases 0..5 of its own, and its delay write-back overlaps
  // phases 0..1 of band b+1 (tail handled with band_q == NUM_BANDS).
  always_comb begin
    state_d     = state_q;
    ph_d        = ph_q;
    band_d      = band_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_data_d  = out_data_q;
    mac_ctrl    = '{y_load_in: 1'b0, y_load_acc: 1'b0, mul_en: 1'b0,
                    acc1_op: ACC1_HOLD, acc2_op: ACC2_HOLD};
    c_we        = 1'b0;
    c_re        = 1'b0;
    c_raddr     = '0;
    c_rb0       = 1'b0;
    d_we        = 1'b0;
    d_waddr     = '0;
    d_wdata     = '0;
    d_re        = 1'b0;
    d_raddr     = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (op_i == OP_COEF) begin
            c_we = coef_ok;
          end else begin
            mac_ctrl.y_load_in = 1'b1;
            band_d             = '0;
            ph_d               = PH_HEAD;
            state_d            = en_q ? ST_RUN : ST_DONE;
          end
        end
      end

      ST_RUN: begin
        case (ph_q)
          PH_HEAD: begin
            // fetch b0 and s1; finish s2 and write s1 of the band before
            if (head) begin
              c_re    = 1'b1;
              c_raddr = coef_addr(band_q, COEF_B0);
              c_rb0   = 1'b1;
              d_re    = 1'b1;
              d_raddr = dly_addr(band_q, DLY_S1);
            end
            if (prev) begin
              mac_ctrl.acc2_op = ACC2_SUB;
              d_we             = 1'b1;
              d_waddr          = dly_addr(band_prev, DLY_S1);
              d_wdata          = s1_new;
            end
            ph_d = PH_MUL_B0;
          end
          PH_MUL_B0: begin
            // b0*x; write s2 of the band before
            if (prev) begin
              d_we    = 1'b1;
              d_waddr = dly_addr(band_prev, DLY_S2);
              d_wdata = s2_new;
            end
            if (head) begin
              mac_ctrl.mul_en = 1'b1;
              c_re            = 1'b1;
              c_raddr         = coef_addr(band_q, COEF_B1);
              ph_d            = PH_ACC_S1;
            end else begin
              state_d = ST_DONE;
              ph_d    = PH_HEAD;
            end
          end
          PH_ACC_S1: begin
            // b0*x + s1; b1*x; fetch b2 and s2
            mac_ctrl.acc1_op = ACC1_LOAD;
            mac_ctrl.mul_en  = 1'b1;
            c_re             = 1'b1;
            c_raddr          = coef_addr(band_q, COEF_B2);
            d_re             = 1'b1;
            d_raddr          = dly_addr(band_q, DLY_S2);
            ph_d             = PH_Y;
          end
          PH_Y: begin
            // y out; b1*x + s2; b2*x
            mac_ctrl.y_load_acc = 1'b1;
            mac_ctrl.acc1_op    = ACC1_LOAD;
            mac_ctrl.mul_en     = 1'b1;
            c_re                = 1'b1;
            c_raddr             = coef_addr(band_q, COEF_A1);
            ph_d                = PH_ACC2;
          end
          PH_ACC2: begin
            // acc2 = b2*x; a1*y
            mac_ctrl.acc2_op = ACC2_LOAD;
            mac_ctrl.mul_en  = 1'b1;
            c_re             = 1'b1;
            c_raddr          = coef_addr(band_q, COEF_A2);
            ph_d             = PH_SUB1;
          end
          PH_SUB1: begin
            // acc1 -= a1*y; a2*y; move to the next band
            mac_ctrl.acc1_op = ACC1_SUB;
            mac_ctrl.mul_en  = 1'b1;
            band_d           = band_q + BANDC_W'(1);
            ph_d             = PH_HEAD;
          end
          default: begin
            ph_d = PH_HEAD;
          end
        endcase
      end

      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = y;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_data_q;

`ifndef SYNTHESIS
  // Delay write-back never targets the entry being read in the same cycle
  a_dly_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_we && d_re |-> d_waddr != d_raddr)
    else $error("delay RAM read and write hit the same entry");

  // Coefficient RAM is only written while the cascade is not running
  a_coef_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_we |-> !c_re && state_q == ST_IDLE)
    else $error("coefficient write during cascade run");

  // Bypassed sample goes straight to result staging
  a_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && op_i == OP_SAMPLE && !en_q |=> state_q == ST_DONE)
    else $error("bypassed sample did not go to result staging");

  // Band counter stays within the cascade
  a_band_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> band_q <= BANDC_W'(NUM_BANDS))
    else $error("band counter out of range");

  // A free output register takes the result on the next edge
  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && !out_valid_q |=> out_valid_o && state_q == ST_IDLE)
    else $error("result not registered");
`endif

endmodule
